>>> hw/rtl/lmra_pkg.sv
// Shared constants, types and helpers for the LED matrix rain animator.
package lmra_pkg;

    localparam int COL_W           = 5;
    localparam int ROW_W           = 5;
    localparam int ADDR_W          = COL_W + ROW_W;
    localparam int MAX_COLS        = 32;
    localparam int MAX_ROWS        = 32;
    localparam int HEIGHT_W        = 6;
    localparam int LEVEL_W         = 8;
    localparam int TIMER_W         = 16;
    localparam int ELAPSED_W       = 10;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;
    localparam int DIVIDEND_W      = 32;
    localparam int DIVISOR_W       = 17;
    localparam int FASTEST_STEP_MS = 11;
    localparam int SPAWN_MODULUS   = 100000;
    localparam int DENSITY_MAX     = 100;

    // largest shifted modulus that still fits a 32-bit word
    localparam int          SPAWN_MOD_SHIFT = 15;
    localparam logic [31:0] SPAWN_MOD_TOP   = 32'(SPAWN_MODULUS) << SPAWN_MOD_SHIFT;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_DIV_DECAY,
        OP_DEC_RD,
        OP_DEC_WR,
        OP_STEP,
        OP_END,
        OP_DIV_AGE,
        OP_AGE_WR,
        OP_FIN,
        OP_DIV_SPAWN,
        OP_SPAWN,
        OP_PIX_RD,
        OP_PIX_OUT
    } t_op;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_PIX_RD,
        ST_PIX_OUT,
        ST_DEC_DIV,
        ST_DEC_WAIT,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_STEP_CHK,
        ST_STEP,
        ST_STEP_POST,
        ST_END,
        ST_AGE_DIV,
        ST_AGE_WAIT,
        ST_AGE_WR,
        ST_FIN,
        ST_SPAWN_DIV,
        ST_SPAWN_WAIT,
        ST_SPAWN_CHK
    } t_state;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic div_done;
        logic kind;
        logic y_last;
        logic active;
        logic budget_ge;
        logic head_ge_h;
        logic spawn_hit;
        logic out_free;
    } t_stat;

    // channel * level / 255, exact for 16-bit products
    function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] b);
        logic [15:0] x;
        logic [16:0] s;
        begin
            x = c * b;
            s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
            scale_channel = s[15:8];
        end
    endfunction

endpackage

>>> hw/rtl/lmra_item_if.sv
// Input item channel: valid/ready handshake with the item fields.
interface lmra_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [4:0]  column;
    logic [4:0]  row;
    logic [9:0]  elapsed_ms;
    logic [31:0] rand_word;

    modport source (output valid, kind, column, row, elapsed_ms, rand_word, input ready);
    modport sink   (input valid, kind, column, row, elapsed_ms, rand_word, output ready);
endinterface

>>> hw/rtl/lmra_res_if.sv
// Result channel: valid/ready handshake with the pixel colour.
interface lmra_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> hw/rtl/lmra_div.sv
// Restoring divider, one quotient bit per cycle.
module lmra_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lmra_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [lmra_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [lmra_pkg::DIVIDEND_W-1:0]     o_quot
);
    logic [lmra_pkg::DIVIDEND_W-1:0] r_quo;
    logic [lmra_pkg::DIVISOR_W-1:0]  r_rem;
    logic [lmra_pkg::DIVISOR_W-1:0]  r_div;
    logic [4:0]                      r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [lmra_pkg::DIVISOR_W:0]    n_sh;
    logic                            n_ge;
    logic [lmra_pkg::DIVISOR_W:0]    n_rem;

    // trial subtraction
    always_comb begin
        n_sh  = {r_rem, r_quo[lmra_pkg::DIVIDEND_W-1]};
        n_ge  = n_sh >= {1'b0, r_div};
        n_rem = n_ge ? (n_sh - {1'b0, r_div}) : n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[lmra_pkg::DIVIDEND_W-2:0], n_ge};
            r_rem <= n_rem[lmra_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

>>> hw/rtl/lmra_ctrl.sv
// Controller state machine sequencing reads, fades, drop steps and spawns.
module lmra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  lmra_pkg::t_stat i_stat,
    output lmra_pkg::t_cmd  o_cmd
);
    lmra_pkg::t_state r_state;
    lmra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lmra_pkg::ST_CLEAR;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lmra_pkg::ST_CLEAR:     if (i_stat.clr_last) n_state = lmra_pkg::ST_IDLE;
            lmra_pkg::ST_IDLE:      if (i_in_valid) n_state = lmra_pkg::ST_DISPATCH;
            lmra_pkg::ST_DISPATCH:  n_state = i_stat.kind ? lmra_pkg::ST_PIX_RD
                                                          : lmra_pkg::ST_DEC_DIV;
            lmra_pkg::ST_PIX_RD:    n_state = lmra_pkg::ST_PIX_OUT;
            lmra_pkg::ST_PIX_OUT:   if (i_stat.out_free) n_state = lmra_pkg::ST_IDLE;
            lmra_pkg::ST_DEC_DIV:   n_state = lmra_pkg::ST_DEC_WAIT;
            lmra_pkg::ST_DEC_WAIT:  if (i_stat.div_done) n_state = lmra_pkg::ST_DEC_RD;
            lmra_pkg::ST_DEC_RD:    n_state = lmra_pkg::ST_DEC_WR;
            lmra_pkg::ST_DEC_WR: begin
                if (!i_stat.y_last)      n_state = lmra_pkg::ST_DEC_RD;
                else if (i_stat.active)  n_state = lmra_pkg::ST_STEP_CHK;
                else                     n_state = lmra_pkg::ST_SPAWN_DIV;
            end
            lmra_pkg::ST_STEP_CHK:  n_state = i_stat.budget_ge ? lmra_pkg::ST_STEP
                                                               : lmra_pkg::ST_FIN;
            lmra_pkg::ST_STEP:      n_state = lmra_pkg::ST_STEP_POST;
            lmra_pkg::ST_STEP_POST: n_state = i_stat.head_ge_h ? lmra_pkg::ST_END
                                                               : lmra_pkg::ST_AGE_DIV;
            lmra_pkg::ST_END:       n_state = lmra_pkg::ST_IDLE;
            lmra_pkg::ST_AGE_DIV:   n_state = lmra_pkg::ST_AGE_WAIT;
            lmra_pkg::ST_AGE_WAIT:  if (i_stat.div_done) n_state = lmra_pkg::ST_AGE_WR;
            lmra_pkg::ST_AGE_WR:    n_state = lmra_pkg::ST_STEP_CHK;
            lmra_pkg::ST_FIN:       n_state = lmra_pkg::ST_IDLE;
            lmra_pkg::ST_SPAWN_DIV: n_state = lmra_pkg::ST_SPAWN_WAIT;
            lmra_pkg::ST_SPAWN_WAIT: if (i_stat.div_done) n_state = lmra_pkg::ST_SPAWN_CHK;
            lmra_pkg::ST_SPAWN_CHK: n_state = lmra_pkg::ST_IDLE;
            default:                n_state = lmra_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.op       = lmra_pkg::OP_NONE;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            lmra_pkg::ST_CLEAR:     o_cmd.op = lmra_pkg::OP_CLEAR;
            lmra_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = lmra_pkg::OP_LATCH;
            end
            lmra_pkg::ST_PIX_RD:    o_cmd.op = lmra_pkg::OP_PIX_RD;
            lmra_pkg::ST_PIX_OUT:   if (i_stat.out_free) o_cmd.op = lmra_pkg::OP_PIX_OUT;
            lmra_pkg::ST_DEC_DIV:   o_cmd.op = lmra_pkg::OP_DIV_DECAY;
            lmra_pkg::ST_DEC_RD:    o_cmd.op = lmra_pkg::OP_DEC_RD;
            lmra_pkg::ST_DEC_WR:    o_cmd.op = lmra_pkg::OP_DEC_WR;
            lmra_pkg::ST_STEP:      o_cmd.op = lmra_pkg::OP_STEP;
            lmra_pkg::ST_END:       o_cmd.op = lmra_pkg::OP_END;
            lmra_pkg::ST_AGE_DIV:   o_cmd.op = lmra_pkg::OP_DIV_AGE;
            lmra_pkg::ST_AGE_WR:    o_cmd.op = lmra_pkg::OP_AGE_WR;
            lmra_pkg::ST_FIN:       o_cmd.op = lmra_pkg::OP_FIN;
            lmra_pkg::ST_SPAWN_DIV: o_cmd.op = lmra_pkg::OP_DIV_SPAWN;
            lmra_pkg::ST_SPAWN_CHK: if (i_stat.spawn_hit) o_cmd.op = lmra_pkg::OP_SPAWN;
            default:                o_cmd.op = lmra_pkg::OP_NONE;
        endcase
    end
endmodule

>>> hw/rtl/lmra_dp.sv
// Datapath: config registers, column state, brightness memory, divider, output register.
module lmra_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lmra_pkg::t_cmd                     i_cmd,
    output lmra_pkg::t_stat                    o_stat,
    input  logic                               i_cfg_we,
    input  logic [lmra_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lmra_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_kind,
    input  logic [lmra_pkg::COL_W-1:0]         i_column,
    input  logic [lmra_pkg::ROW_W-1:0]         i_row,
    input  logic [lmra_pkg::ELAPSED_W-1:0]     i_elapsed_ms,
    input  logic [31:0]                        i_rand_word,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue
);
    // configuration
    logic [15:0] r_speed_cfg;
    logic [15:0] r_fade_cfg;
    logic [6:0]  r_density_cfg;
    logic [23:0] r_color;
    logic [5:0]  r_height_cfg;

    // latched item and tick working values
    logic                                r_kind;
    logic [lmra_pkg::COL_W-1:0]          r_col;
    logic [lmra_pkg::ROW_W-1:0]          r_row;
    logic [lmra_pkg::ELAPSED_W-1:0]      r_elapsed;
    logic [31:0]                         r_rand;
    logic [lmra_pkg::ELAPSED_W-1:0]      r_budget;
    logic                                r_stepped;
    logic [lmra_pkg::ROW_W-1:0]          r_y;
    logic [lmra_pkg::ADDR_W-1:0]         r_clr_addr;

    // per-column drop state
    logic [lmra_pkg::MAX_COLS-1:0]       r_active;
    logic [lmra_pkg::HEIGHT_W-1:0]       r_head  [lmra_pkg::MAX_COLS];
    logic [lmra_pkg::TIMER_W-1:0]        r_timer [lmra_pkg::MAX_COLS];

    // brightness memory
    logic [7:0]    r_mem [lmra_pkg::MAX_COLS*lmra_pkg::MAX_ROWS];
    logic [7:0]    r_rdata;

    // output register
    logic          r_out_valid;
    logic [7:0]    r_red;
    logic [7:0]    r_green;
    logic [7:0]    r_blue;

    // effective settings
    logic [15:0]                   n_speed;
    logic [15:0]                   n_fade;
    logic [6:0]                    n_density;
    logic [lmra_pkg::HEIGHT_W-1:0] n_height;
    logic [lmra_pkg::HEIGHT_W-1:0] n_head;
    logic [15:0]                   n_timer;

    always_comb begin
        n_speed   = (r_speed_cfg < 16'(lmra_pkg::FASTEST_STEP_MS))
                    ? 16'(lmra_pkg::FASTEST_STEP_MS) : r_speed_cfg;
        n_fade    = (r_fade_cfg == 16'd0) ? 16'd1 : r_fade_cfg;
        n_density = (r_density_cfg > 7'(lmra_pkg::DENSITY_MAX))
                    ? 7'(lmra_pkg::DENSITY_MAX) : r_density_cfg;
        if (r_height_cfg == 6'd0)
            n_height = 6'd1;
        else if (r_height_cfg > 6'(lmra_pkg::MAX_ROWS))
            n_height = 6'(lmra_pkg::MAX_ROWS);
        else
            n_height = r_height_cfg;
        n_head  = r_head[r_col];
        n_timer = r_timer[r_col];
    end

    // divider operands
    logic [17:0]                         n_elapsed_x255;
    logic [17:0]                         n_budget_x255;
    logic                                w_div_start;
    logic [lmra_pkg::DIVIDEND_W-1:0]     n_dividend;
    logic [lmra_pkg::DIVISOR_W-1:0]      n_divisor;
    logic                                w_div_busy;
    logic                                w_div_done;
    logic [lmra_pkg::DIVIDEND_W-1:0]     w_quot;

    always_comb begin
        n_elapsed_x255 = {r_elapsed, 8'd0} - {8'd0, r_elapsed};
        n_budget_x255  = {r_budget, 8'd0} - {8'd0, r_budget};
        w_div_start    = 1'b0;
        n_dividend     = {14'd0, n_elapsed_x255};
        n_divisor      = {1'b0, n_fade};
        case (i_cmd.op)
            lmra_pkg::OP_DIV_DECAY: begin
                w_div_start = 1'b1;
            end
            lmra_pkg::OP_DIV_AGE: begin
                w_div_start = 1'b1;
                n_dividend  = {14'd0, n_budget_x255};
            end
            default: w_div_start = 1'b0;
        endcase
    end

    lmra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // spawn word modulo 100000: four compare-and-subtract stages a cycle
    logic [31:0] r_mod;
    logic [31:0] r_mod_sub;
    logic [1:0]  r_mod_cnt;
    logic        r_mod_busy;
    logic        r_mod_done;
    logic [31:0] n_mod;

    always_comb begin
        n_mod = r_mod;
        for (int k = 0; k < 4; k++) begin
            if (n_mod >= (r_mod_sub >> k)) n_mod = n_mod - (r_mod_sub >> k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_busy <= 1'b0;
            r_mod_done <= 1'b0;
            r_mod_cnt  <= '0;
        end else begin
            r_mod_done <= 1'b0;
            if (i_cmd.op == lmra_pkg::OP_DIV_SPAWN) begin
                r_mod_busy <= 1'b1;
                r_mod_cnt  <= '0;
            end else if (r_mod_busy) begin
                r_mod_cnt <= r_mod_cnt + 2'd1;
                if (r_mod_cnt == 2'd3) begin
                    r_mod_busy <= 1'b0;
                    r_mod_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lmra_pkg::OP_DIV_SPAWN) begin
            r_mod     <= r_rand;
            r_mod_sub <= lmra_pkg::SPAWN_MOD_TOP;
        end else if (r_mod_busy) begin
            r_mod     <= n_mod;
            r_mod_sub <= r_mod_sub >> 4;
        end
    end

    // faded level, lit level from age, spawn test
    logic [17:0] n_q;
    logic [7:0]  n_faded;
    logic [7:0]  n_aged;
    logic [16:0] n_thresh;
    logic        n_spawn_hit;

    always_comb begin
        n_q         = w_quot[17:0];
        n_faded     = ({10'd0, r_rdata} > n_q) ? (r_rdata - n_q[7:0]) : 8'd0;
        n_aged      = (n_q < 18'd255) ? (8'd255 - n_q[7:0]) : 8'd0;
        n_thresh    = 17'(n_density * r_elapsed);
        n_spawn_hit = (n_density != 7'd0) && (r_mod[16:0] < n_thresh);
    end

    // memory port selection; a pixel read keeps its address while the result waits
    logic                        w_we;
    logic [lmra_pkg::ADDR_W-1:0] n_waddr;
    logic [7:0]                  n_wdata;
    logic [lmra_pkg::ADDR_W-1:0] n_raddr;

    always_comb begin
        w_we    = 1'b0;
        n_waddr = {r_col, r_y};
        n_wdata = 8'd255;
        n_raddr = r_kind ? {r_col, r_row} : {r_col, r_y};
        case (i_cmd.op)
            lmra_pkg::OP_CLEAR: begin
                w_we    = 1'b1;
                n_waddr = r_clr_addr;
                n_wdata = 8'd0;
            end
            lmra_pkg::OP_DEC_WR: begin
                w_we    = 1'b1;
                n_wdata = n_faded;
            end
            lmra_pkg::OP_AGE_WR: begin
                w_we    = 1'b1;
                n_waddr = {r_col, n_head[lmra_pkg::ROW_W-1:0]};
                n_wdata = n_aged;
            end
            lmra_pkg::OP_FIN: begin
                w_we    = r_stepped;
                n_waddr = {r_col, n_head[lmra_pkg::ROW_W-1:0]};
            end
            lmra_pkg::OP_SPAWN: begin
                w_we    = 1'b1;
                n_waddr = {r_col, {lmra_pkg::ROW_W{1'b0}}};
            end
            lmra_pkg::OP_PIX_RD: n_raddr = {r_col, r_row};
            default:             w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[n_waddr] <= n_wdata;
        r_rdata <= r_mem[n_raddr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_cfg   <= 16'd100;
            r_fade_cfg    <= 16'd1000;
            r_density_cfg <= 7'd10;
            r_color       <= 24'h00FF00;
            r_height_cfg  <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lmra_pkg::CFG_SPEED:   r_speed_cfg   <= i_cfg_data[15:0];
                lmra_pkg::CFG_FADE:    r_fade_cfg    <= i_cfg_data[15:0];
                lmra_pkg::CFG_DENSITY: r_density_cfg <= i_cfg_data[6:0];
                lmra_pkg::CFG_COLOR:   r_color       <= i_cfg_data;
                lmra_pkg::CFG_HEIGHT:  r_height_cfg  <= i_cfg_data[5:0];
                default:               r_color       <= r_color;
            endcase
        end
    end

    // item latch and tick working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            lmra_pkg::OP_LATCH: begin
                r_kind    <= i_kind;
                r_col     <= i_column;
                r_row     <= i_row;
                r_elapsed <= i_elapsed_ms;
                r_rand    <= i_rand_word;
                r_budget  <= i_elapsed_ms;
                r_stepped <= 1'b0;
                r_y       <= '0;
            end
            lmra_pkg::OP_DEC_WR: r_y <= r_y + 5'd1;
            lmra_pkg::OP_STEP: begin
                r_budget  <= r_budget - n_timer[lmra_pkg::ELAPSED_W-1:0];
                r_stepped <= 1'b1;
            end
            default: r_y <= r_y;
        endcase
    end

    // column drop state and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_clr_addr <= '0;
            for (int c = 0; c < lmra_pkg::MAX_COLS; c++) begin
                r_head[c]  <= '0;
                r_timer[c] <= '0;
            end
        end else begin
            case (i_cmd.op)
                lmra_pkg::OP_CLEAR: r_clr_addr <= r_clr_addr + 10'd1;
                lmra_pkg::OP_STEP: begin
                    r_timer[r_col] <= n_speed;
                    r_head[r_col]  <= n_head + 6'd1;
                end
                lmra_pkg::OP_END: r_active[r_col] <= 1'b0;
                lmra_pkg::OP_FIN: r_timer[r_col] <= n_timer - {6'd0, r_budget};
                lmra_pkg::OP_SPAWN: begin
                    r_active[r_col] <= 1'b1;
                    r_head[r_col]   <= '0;
                    r_timer[r_col]  <= n_speed;
                end
                default: r_clr_addr <= r_clr_addr;
            endcase
        end
    end

    // result register
    logic n_row_ok;
    assign n_row_ok = {1'b0, r_row} < n_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == lmra_pkg::OP_PIX_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lmra_pkg::OP_PIX_OUT) begin
            r_red   <= n_row_ok ? lmra_pkg::scale_channel(r_color[23:16], r_rdata) : 8'd0;
            r_green <= n_row_ok ? lmra_pkg::scale_channel(r_color[15:8], r_rdata) : 8'd0;
            r_blue  <= n_row_ok ? lmra_pkg::scale_channel(r_color[7:0], r_rdata) : 8'd0;
        end
    end

    // status to the controller; done covers both the divider and the spawn remainder
    always_comb begin
        o_stat.clr_last  = &r_clr_addr;
        o_stat.div_busy  = w_div_busy;
        o_stat.div_done  = w_div_done | r_mod_done;
        o_stat.kind      = r_kind;
        o_stat.y_last    = ({1'b0, r_y} == (n_height - 6'd1));
        o_stat.active    = r_active[r_col];
        o_stat.budget_ge = {6'd0, r_budget} >= n_timer;
        o_stat.head_ge_h = n_head >= n_height;
        o_stat.spawn_hit = n_spawn_hit;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
endmodule

>>> hw/rtl/led_matrix_rain_animator.sv
// Top level of the LED matrix rain animator.
// Falling-drop animator for a panel of 32 columns by up to 32 rows. After reset the block sweeps
// its 1024-entry brightness memory to zero, one entry a cycle, and takes no item until the sweep
// is done; configuration writes are taken at any time the block is idle. A pixel read passes
// a memory read and the output load, which waits for a free output register, and returns
// one result, held in an output register until transferred. A column tick returns nothing:
// the fade division, a read and a write per used row for the fade sweep over the memory with
// one read and one write port, then for an active column the drop steps (an age division for
// each step that does not end the drop), else the spawn test, which reduces the random word
// modulo 100000 by compare and subtract, four stages a cycle. The fade and age divisions share
// one bit-per-cycle divider, which sets most of the tick time. One item is worked at a time.
module led_matrix_rain_animator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lmra_item_if.sink                        i_item,
    lmra_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [lmra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lmra_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    lmra_pkg::t_cmd  w_cmd;
    lmra_pkg::t_stat w_stat;

    lmra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lmra_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_item.kind),
        .i_column     (i_item.column),
        .i_row        (i_item.row),
        .i_elapsed_ms (i_item.elapsed_ms),
        .i_rand_word  (i_item.rand_word),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_red        (o_res.red),
        .o_green      (o_res.green),
        .o_blue       (o_res.blue)
    );

    assign i_item.ready = w_cmd.in_ready;

    // an input transfer always latches the item
    a_xfer_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |-> (w_cmd.op == lmra_pkg::OP_LATCH))
        else $error("input transfer without latch");

    // the divider is never restarted mid-division
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == lmra_pkg::OP_DIV_DECAY || w_cmd.op == lmra_pkg::OP_DIV_AGE
         || w_cmd.op == lmra_pkg::OP_DIV_SPAWN) |-> !w_stat.div_busy)
        else $error("divider started while busy");

    // a result appears only after a pixel output load
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_cmd.op == lmra_pkg::OP_PIX_OUT))
        else $error("result without pixel read");
endmodule
